@@ rtl/sacs_pkg.sv @@
package sacs_pkg;

  localparam int MAX_TEXT  = 1024;
  localparam int MAX_NODES = 2048;
  localparam int ALPHABET  = 256;

  localparam int SYM_W     = 8;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int LINK_W    = NODE_W + 1;
  localparam int USED_W    = $clog2(MAX_NODES + 1);
  localparam int LEN_W     = $clog2(MAX_TEXT + 1);
  localparam int SIDX_W    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int TADDR_W   = NODE_W + SIDX_W;
  localparam int TDEPTH    = MAX_NODES * (2 ** SIDX_W);
  localparam int POS_W     = 16;
  localparam int CNT_W     = SIDX_W + 1;

  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(MAX_NODES);
  localparam logic [POS_W-1:0]  POS_MAX = {POS_W{1'b1}};

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_EXTEND = 2'd1;
  localparam logic [1:0] FUNC_MATCH  = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [LINK_W-1:0] link;
  } node_word_t;

  localparam int NWORD_W = LEN_W + LINK_W;

endpackage

@@ rtl/sacs_ram.sv @@
module sacs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/suffix_automaton_common_substring.sv @@
// Suffix automaton longest common substring engine. Pulse start with func and symbol while
// busy is low; exactly one result follows on done for a single cycle and cannot be held off,
// so it must be captured when done is high. Node lengths and links live in one memory and the
// transition table (one word per node and symbol) in another, each with one read and one
// write a cycle. A match step follows suffix links until a transition on the symbol is found
// or the root is reached. An extend walks the suffix links until it meets an existing
// transition or runs out of links, and a clone adds a row copy and a redirect walk.
// No-operation and a refused extend report done without leaving idle.
// After reset and after every clear the transition memory is swept, one entry a cycle,
// over all MAX_NODES * ALPHABET entries while busy stays high.
module suffix_automaton_common_substring (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [1:0]                   func,
  input  logic [sacs_pkg::SYM_W-1:0]   symbol,
  output logic                         busy,
  output logic                         done,
  output logic                         overflow,
  output logic [sacs_pkg::LEN_W-1:0]   cur_match_len,
  output logic [sacs_pkg::LEN_W-1:0]   best_len,
  output logic [sacs_pkg::POS_W-1:0]   best_end
);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_X_RD, S_X_EV, S_Q_EV, S_COPY,
    S_R_RD, S_R_EV, S_W_Q, S_W_CUR, S_M_RD, S_M_EV
  } state_t;

  state_t state;

  logic [sacs_pkg::SYM_W-1:0]   sym;
  logic [sacs_pkg::LINK_W-1:0]  p;
  logic [sacs_pkg::NODE_W-1:0]  cur, cl, q;
  logic [sacs_pkg::LEN_W-1:0]   len_p, len_q;
  logic [sacs_pkg::LINK_W-1:0]  link_cur;
  logic [sacs_pkg::USED_W-1:0]  nodes_used;
  logic [sacs_pkg::NODE_W-1:0]  last_node;
  logic [sacs_pkg::LEN_W-1:0]   last_len;
  logic [sacs_pkg::LEN_W-1:0]   text_count;
  logic [sacs_pkg::NODE_W-1:0]  match_node;
  logic [sacs_pkg::LEN_W-1:0]   match_len, longest;
  logic [sacs_pkg::POS_W-1:0]   longest_end, query_pos;
  logic                         via_link, emit;
  logic [sacs_pkg::TADDR_W-1:0] sweep;
  logic [sacs_pkg::CNT_W-1:0]   cnt;

  logic                         n_we, t_we;
  logic [sacs_pkg::NODE_W-1:0]  n_waddr, n_raddr;
  sacs_pkg::node_word_t         n_wdata, n_rdata;
  logic [sacs_pkg::TADDR_W-1:0] t_waddr, t_raddr;
  logic [sacs_pkg::NODE_W-1:0]  t_wdata, t_rdata;
  logic [sacs_pkg::SIDX_W-1:0]  sidx;

  assign sidx = sacs_pkg::SIDX_W'(sym);

  sacs_ram #(.WIDTH(sacs_pkg::NWORD_W), .DEPTH(sacs_pkg::MAX_NODES)) u_node (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  sacs_ram #(.WIDTH(sacs_pkg::NODE_W), .DEPTH(sacs_pkg::TDEPTH)) u_trans (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    n_we    = 1'b0;
    n_waddr = '0;
    n_wdata = '0;
    n_raddr = p[sacs_pkg::NODE_W-1:0];
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = '0;
    t_raddr = {p[sacs_pkg::NODE_W-1:0], sidx};
    case (state)
      S_SWEEP: begin
        t_we    = 1'b1;
        t_waddr = sweep;
        if (sweep == '0) begin
          n_we         = 1'b1;
          n_wdata.len  = '0;
          n_wdata.link = sacs_pkg::NO_LINK;
        end
      end
      S_X_EV: begin
        n_raddr = t_rdata;
        if (t_rdata == '0) begin
          t_we    = 1'b1;
          t_waddr = {p[sacs_pkg::NODE_W-1:0], sidx};
          t_wdata = cur;
        end
      end
      S_Q_EV: begin
        if (n_rdata.len != len_p + 1'b1) begin
          n_we         = 1'b1;
          n_waddr      = nodes_used[sacs_pkg::NODE_W-1:0];
          n_wdata.len  = len_p + 1'b1;
          n_wdata.link = n_rdata.link;
        end
      end
      S_COPY: begin
        t_raddr = {q, cnt[sacs_pkg::SIDX_W-1:0]};
        if (cnt != '0) begin
          t_we    = 1'b1;
          t_waddr = {cl, sacs_pkg::SIDX_W'(cnt - 1'b1)};
          t_wdata = t_rdata;
        end
      end
      S_R_EV: begin
        if (t_rdata == q) begin
          t_we    = 1'b1;
          t_waddr = {p[sacs_pkg::NODE_W-1:0], sidx};
          t_wdata = cl;
        end
      end
      S_W_Q: begin
        n_we         = 1'b1;
        n_waddr      = q;
        n_wdata.len  = len_q;
        n_wdata.link = sacs_pkg::LINK_W'(cl);
      end
      S_W_CUR: begin
        n_we         = 1'b1;
        n_waddr      = cur;
        n_wdata.len  = last_len + 1'b1;
        n_wdata.link = link_cur;
      end
      S_M_RD, S_M_EV: begin
        n_raddr = match_node;
        t_raddr = {match_node, sidx};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    logic [sacs_pkg::LEN_W-1:0] ml;
    logic [sacs_pkg::LEN_W-1:0] ml_fin;
    logic                       fin;
    ml     = via_link ? n_rdata.len : match_len;
    ml_fin = ml;
    fin    = 1'b0;
    done   <= 1'b0;
    if (rst) begin
      state      <= S_SWEEP;
      sweep      <= '0;
      emit       <= 1'b0;
      nodes_used <= sacs_pkg::USED_W'(1);
      last_node  <= '0;
      last_len   <= '0;
      text_count <= '0;
      match_node <= '0;
      match_len  <= '0;
      longest    <= '0;
      longest_end <= '0;
      query_pos  <= '0;
    end else begin
      case (state)
        S_SWEEP: begin
          sweep <= sweep + 1'b1;
          if (sweep == sacs_pkg::TADDR_W'(sacs_pkg::TDEPTH - 1)) begin
            state <= S_IDLE;
            if (emit) begin
              done          <= 1'b1;
              overflow      <= 1'b0;
              cur_match_len <= '0;
              best_len      <= '0;
              best_end      <= '0;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            sym <= symbol;
            case (func)
              sacs_pkg::FUNC_CLEAR: begin
                state      <= S_SWEEP;
                sweep      <= '0;
                emit       <= 1'b1;
                nodes_used <= sacs_pkg::USED_W'(1);
                last_node  <= '0;
                last_len   <= '0;
                text_count <= '0;
                match_node <= '0;
                match_len  <= '0;
                longest    <= '0;
                longest_end <= '0;
                query_pos  <= '0;
              end
              sacs_pkg::FUNC_EXTEND: begin
                if ({1'b0, symbol} >= 9'(sacs_pkg::ALPHABET)) begin
                  done          <= 1'b1;
                  overflow      <= 1'b0;
                  cur_match_len <= match_len;
                  best_len      <= longest;
                  best_end      <= longest_end;
                end else if (32'(text_count) >= sacs_pkg::MAX_TEXT ||
                             32'(nodes_used) + 2 > sacs_pkg::MAX_NODES) begin
                  done          <= 1'b1;
                  overflow      <= 1'b1;
                  cur_match_len <= match_len;
                  best_len      <= longest;
                  best_end      <= longest_end;
                end else begin
                  cur        <= nodes_used[sacs_pkg::NODE_W-1:0];
                  nodes_used <= nodes_used + 1'b1;
                  p          <= sacs_pkg::LINK_W'(last_node);
                  state      <= S_X_RD;
                end
              end
              sacs_pkg::FUNC_MATCH: begin
                via_link <= 1'b0;
                if ({1'b0, symbol} >= 9'(sacs_pkg::ALPHABET)) begin
                  match_node <= '0;
                  match_len  <= '0;
                  ml_fin     = '0;
                  fin        = 1'b1;
                end else begin
                  state <= S_M_RD;
                end
              end
              default: begin
                done          <= 1'b1;
                overflow      <= 1'b0;
                cur_match_len <= match_len;
                best_len      <= longest;
                best_end      <= longest_end;
              end
            endcase
          end
        end
        S_X_RD: state <= S_X_EV;
        S_X_EV: begin
          if (t_rdata == '0) begin
            if (n_rdata.link == sacs_pkg::NO_LINK) begin
              link_cur <= '0;
              state    <= S_W_CUR;
            end else begin
              p     <= n_rdata.link;
              state <= S_X_RD;
            end
          end else begin
            q     <= t_rdata;
            len_p <= n_rdata.len;
            state <= S_Q_EV;
          end
        end
        S_Q_EV: begin
          if (n_rdata.len == len_p + 1'b1) begin
            link_cur <= sacs_pkg::LINK_W'(q);
            state    <= S_W_CUR;
          end else begin
            cl         <= nodes_used[sacs_pkg::NODE_W-1:0];
            nodes_used <= nodes_used + 1'b1;
            len_q      <= n_rdata.len;
            cnt        <= '0;
            state      <= S_COPY;
          end
        end
        S_COPY: begin
          cnt <= cnt + 1'b1;
          if (cnt == sacs_pkg::CNT_W'(sacs_pkg::ALPHABET)) begin
            state <= S_R_RD;
          end
        end
        S_R_RD: state <= S_R_EV;
        S_R_EV: begin
          if (t_rdata == q && n_rdata.link != sacs_pkg::NO_LINK) begin
            p     <= n_rdata.link;
            state <= S_R_RD;
          end else begin
            state <= S_W_Q;
          end
        end
        S_W_Q: begin
          link_cur <= sacs_pkg::LINK_W'(cl);
          state    <= S_W_CUR;
        end
        S_W_CUR: begin
          last_node   <= cur;
          last_len    <= last_len + 1'b1;
          text_count  <= text_count + 1'b1;
          match_node  <= '0;
          match_len   <= '0;
          longest     <= '0;
          longest_end <= '0;
          query_pos   <= '0;
          state       <= S_IDLE;
          done          <= 1'b1;
          overflow      <= 1'b0;
          cur_match_len <= '0;
          best_len      <= '0;
          best_end      <= '0;
        end
        S_M_RD: state <= S_M_EV;
        S_M_EV: begin
          if (t_rdata != '0) begin
            match_node <= t_rdata;
            ml_fin     = ml + 1'b1;
            match_len  <= ml_fin;
            fin        = 1'b1;
          end else if (match_node == '0) begin
            match_len <= ml;
            fin       = 1'b1;
          end else begin
            match_node <= n_rdata.link[sacs_pkg::NODE_W-1:0];
            match_len  <= ml;
            via_link   <= 1'b1;
            state      <= S_M_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (fin) begin
        state         <= S_IDLE;
        done          <= 1'b1;
        overflow      <= 1'b0;
        cur_match_len <= ml_fin;
        if (ml_fin > longest) begin
          longest     <= ml_fin;
          longest_end <= query_pos;
          best_len    <= ml_fin;
          best_end    <= query_pos;
        end else begin
          best_len    <= longest;
          best_end    <= longest_end;
        end
        if (query_pos != sacs_pkg::POS_MAX) begin
          query_pos <= query_pos + 1'b1;
        end
      end
    end
  end

endmodule
